[rtl/core/proxy_arp_responder_defines.svh]
// Assertion macros shared by the proxy ARP responder RTL.
`ifndef PROXY_ARP_RESPONDER_DEFINES_SVH
`define PROXY_ARP_RESPONDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/par_pkg.sv]
// Shared types and constants of the proxy ARP responder.
`timescale 1ns / 1ps
package par_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;
    localparam int POS_W = 6;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 264;

    localparam logic [POS_W-1:0] POS_MAX        = 6'd63;
    localparam logic [POS_W-1:0] POS_ETYPE_HI   = 6'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO   = 6'd13;
    localparam logic [POS_W-1:0] POS_OP_HI      = 6'd20;
    localparam logic [POS_W-1:0] POS_OP_LO      = 6'd21;
    localparam logic [POS_W-1:0] POS_SMAC_FIRST = 6'd22;
    localparam logic [POS_W-1:0] POS_SMAC_LAST  = 6'd27;
    localparam logic [POS_W-1:0] POS_SIP_FIRST  = 6'd28;
    localparam logic [POS_W-1:0] POS_SIP_LAST   = 6'd31;
    localparam logic [POS_W-1:0] POS_TIP_FIRST  = 6'd38;
    localparam logic [POS_W-1:0] POS_TIP_LAST   = 6'd41;
    // last header byte of a minimum-size (42 byte) ARP frame
    localparam logic [POS_W-1:0] POS_MIN_LAST   = 6'd41;

    localparam logic [15:0] ARP_ETHERTYPE = 16'h0806;
    localparam logic [15:0] ARP_REQUEST   = 16'h0001;

    localparam int               CFG_AW           = 4;
    localparam logic [CFG_AW-1:0] ADDR_HOST_MAC    = 4'h0;
    localparam logic [CFG_AW-1:0] ADDR_ENTRY_COUNT = 4'h8;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_ENTRY = 1'b1
    } t_op;

    typedef struct packed {
        logic             start;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
    } t_req;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic pend_vld;
    } t_scan_sts;

endpackage

[rtl/core/par_parser.sv]
// Frame header parser: byte position tracking and ARP field capture.
`timescale 1ns / 1ps
module par_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_byte_vld,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output par_pkg::t_req o_req
);
    import par_pkg::*;

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [15:0]      r_etype, n_etype;
    logic [15:0]      r_aop,   n_aop;
    logic [MAC_W-1:0] r_smac,  n_smac;
    logic [IP_W-1:0]  r_sip,   n_sip;
    logic [IP_W-1:0]  r_tip,   n_tip;

    always_comb begin
        n_pos   = r_pos;
        n_etype = r_etype;
        n_aop   = r_aop;
        n_smac  = r_smac;
        n_sip   = r_sip;
        n_tip   = r_tip;
        if (i_byte_vld) begin
            if (r_pos == POS_ETYPE_HI || r_pos == POS_ETYPE_LO) begin
                n_etype = {r_etype[7:0], i_byte};
            end else if (r_pos == POS_OP_HI || r_pos == POS_OP_LO) begin
                n_aop = {r_aop[7:0], i_byte};
            end else if (r_pos >= POS_SMAC_FIRST && r_pos <= POS_SMAC_LAST) begin
                n_smac = {r_smac[MAC_W-9:0], i_byte};
            end else if (r_pos >= POS_SIP_FIRST && r_pos <= POS_SIP_LAST) begin
                n_sip = {r_sip[IP_W-9:0], i_byte};
            end else if (r_pos >= POS_TIP_FIRST && r_pos <= POS_TIP_LAST) begin
                n_tip = {r_tip[IP_W-9:0], i_byte};
            end
            if (i_last) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_etype <= '0;
            r_aop   <= '0;
            r_smac  <= '0;
            r_sip   <= '0;
            r_tip   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_etype <= n_etype;
            r_aop   <= n_aop;
            r_smac  <= n_smac;
            r_sip   <= n_sip;
            r_tip   <= n_tip;
        end
    end

    // ethertype and opcode are complete long before the last header byte
    assign o_req.start = i_byte_vld && i_last && (r_pos >= POS_MIN_LAST) &&
                         (r_etype == ARP_ETHERTYPE) && (r_aop == ARP_REQUEST);
    assign o_req.sender_mac = r_smac;
    assign o_req.sender_ip  = r_sip;
    assign o_req.target_ip  = r_tip;

endmodule

[rtl/core/par_table.sv]
// IP to MAC table: single write port, registered single read port.
`timescale 1ns / 1ps
module par_table #(
    parameter int TABLE_DEPTH = par_pkg::TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  par_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output par_pkg::t_entry o_rd_data
);
    import par_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/par_scan.sv]
// Table scan sequencer with one-reply lookahead and output register.
`timescale 1ns / 1ps
module par_scan #(
    parameter int TABLE_DEPTH = par_pkg::TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  par_pkg::t_req                      i_req,
    input  logic [par_pkg::MAC_W-1:0]          i_host_mac,
    input  logic [par_pkg::CNT_W-1:0]          i_entry_count,
    input  par_pkg::t_entry                    i_rd_data,
    output logic                               o_rd_en,
    output logic [AW-1:0]                      o_rd_addr,
    output par_pkg::t_scan_sts                 o_sts,
    output logic                               o_out_vld,
    input  logic                               i_out_rdy,
    output logic [par_pkg::OUT_TDATA_W-1:0]    o_out_data,
    output logic                               o_out_last
);
    import par_pkg::*;

    localparam int ScanMax = (TABLE_DEPTH < MAX_RESULTS) ? TABLE_DEPTH : MAX_RESULTS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_FLUSH
    } t_state;

    t_state                 r_state,    n_state;
    logic [CNT_W-1:0]       r_scan,     n_scan;
    logic [CNT_W-1:0]       r_limit,    n_limit;
    logic                   r_pend_vld, n_pend_vld;
    logic [MAC_W-1:0]       r_pend_mac, n_pend_mac;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;
    logic                   r_out_vld,  n_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                   r_out_last, n_out_last;

    logic             out_free;
    logic             hit;
    logic             push;
    logic             push_last;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] scan_inc;

    assign out_free = !r_out_vld || i_out_rdy;
    assign hit      = (i_rd_data.ip == i_req.target_ip);
    assign limit    = (i_entry_count > CNT_W'(ScanMax)) ? CNT_W'(ScanMax) : i_entry_count;
    assign scan_inc = r_scan + 5'd1;

    always_comb begin
        n_state    = r_state;
        n_scan     = r_scan;
        n_limit    = r_limit;
        n_pend_vld = r_pend_vld;
        n_pend_mac = r_pend_mac;
        n_pend_idx = r_pend_idx;
        push       = 1'b0;
        push_last  = 1'b0;
        o_rd_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_scan  = '0;
                    n_limit = limit;
                    n_state = (limit == '0) ? S_IDLE : S_READ;
                end
            end
            S_READ: begin
                o_rd_en = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                // hold while an older match waits for the output register
                if (!(hit && r_pend_vld && !out_free)) begin
                    if (hit) begin
                        push       = r_pend_vld;
                        n_pend_vld = 1'b1;
                        n_pend_mac = i_rd_data.mac;
                        n_pend_idx = r_scan[IDX_W-1:0];
                    end
                    n_scan  = scan_inc;
                    n_state = (scan_inc == r_limit) ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld  = r_out_vld && !i_out_rdy;
        n_out_data = r_out_data;
        n_out_last = r_out_last;
        if (push) begin
            n_out_vld  = 1'b1;
            n_out_last = push_last;
            n_out_data = {4'b0, r_pend_idx, i_req.sender_ip, i_req.sender_mac,
                          i_req.target_ip, r_pend_mac, i_host_mac, i_req.sender_mac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
        r_scan     <= n_scan;
        r_limit    <= n_limit;
        r_pend_mac <= n_pend_mac;
        r_pend_idx <= n_pend_idx;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_rd_addr      = AW'(r_scan);
    assign o_sts.busy     = (r_state != S_IDLE);
    assign o_sts.pend_vld = r_pend_vld;
    assign o_out_vld      = r_out_vld;
    assign o_out_data     = r_out_data;
    assign o_out_last     = r_out_last;

endmodule

[rtl/core/proxy_arp_responder.sv]
// Proxy ARP responder: parses received frames and answers ARP requests from a table.
//
// Input stream (s_axis): one transfer is either a frame byte (tuser = 0, tlast marks the
// frame's final byte) or a table write (tuser = 1, slot, IP and MAC in tdata).
// Frame bytes and table writes are taken one per cycle while no scan runs.
// On the last byte of an ARP request of at least 42 bytes the block scans table slots
// 0 .. min(entry_count, depth, 16) - 1, each slot by a memory read, then a compare,
// and emits one reply per matching slot in ascending order on m_axis, tlast on the last.
// s_axis_tready stays low for the scan, which any m_axis stall lengthens.
// A stalled m_axis holds the current reply; the scan then waits on the next match.
// Input transfers resume while the final reply still waits in the output register.
// APB: host_mac at 0x0, entry_count at 0x8, 64-bit data; write only while idle.
// Reset clears the parser state, the registers and all control; the table memory is
// not cleared and each slot must be written before a scan reaches it.
`timescale 1ns / 1ps
module proxy_arp_responder #(
    parameter int TABLE_DEPTH = par_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [par_pkg::CFG_AW-1:0]         paddr,
    input  logic [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // frame_byte, entry_index, entry_ip, entry_mac (from bit 0), zero padded
    input  logic [par_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    // opcode
    input  logic                               s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // eth_dst_mac, eth_src_mac, reply_sender_mac, reply_sender_ip, reply_target_mac,
    // reply_target_ip, matched_index (from bit 0), zero padded
    output logic [par_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);
    import par_pkg::*;

    `include "proxy_arp_responder_defines.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [MAC_W-1:0] r_host_mac;
    logic [CNT_W-1:0] r_entry_count;

    logic             cfg_wr;
    logic             in_xfer;
    logic             byte_vld;
    logic             tbl_wr;
    logic [IDX_W-1:0] in_index;
    t_entry           in_entry;
    t_req             req;
    t_entry           rd_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    t_scan_sts        sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_mac    <= '0;
            r_entry_count <= '0;
        end else if (cfg_wr) begin
            if (paddr == ADDR_HOST_MAC) begin
                r_host_mac <= pwdata[MAC_W-1:0];
            end
            if (paddr == ADDR_ENTRY_COUNT) begin
                r_entry_count <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            ADDR_HOST_MAC:    prdata = {16'b0, r_host_mac};
            ADDR_ENTRY_COUNT: prdata = {59'b0, r_entry_count};
            default:          prdata = '0;
        endcase
    end

    assign s_axis_tready = !sts.busy;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign byte_vld      = in_xfer && (s_axis_tuser == OP_FRAME);
    assign in_index      = s_axis_tdata[11:8];
    assign in_entry.ip   = s_axis_tdata[43:12];
    assign in_entry.mac  = s_axis_tdata[91:44];
    // drop writes to slots beyond the table
    assign tbl_wr = in_xfer && (s_axis_tuser == OP_ENTRY) && (32'(in_index) < TABLE_DEPTH);

    par_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (byte_vld),
        .i_byte     (s_axis_tdata[7:0]),
        .i_last     (s_axis_tlast),
        .o_req      (req)
    );

    par_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr),
        .i_wr_addr (AW'(in_index)),
        .i_wr_data (in_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    par_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_host_mac    (r_host_mac),
        .i_entry_count (r_entry_count),
        .i_rd_data     (rd_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_sts         (sts),
        .o_out_vld     (m_axis_tvalid),
        .i_out_rdy     (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

    `PAR_ASSERT_NOW(a_no_pending_when_idle, !sts.busy, !sts.pend_vld,
        "pending reply left behind after scan")
    `PAR_ASSERT_NOW(a_more_replies_follow, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        sts.busy, "non-final reply sent with no scan running")
    `PAR_ASSERT_NOW(a_index_in_table, m_axis_tvalid,
        32'(m_axis_tdata[259:256]) < TABLE_DEPTH, "reply slot beyond table depth")

endmodule
